>>> hdl/sdf_pkg.sv
// Shared types and defaults for the stream duplicate filter.
`timescale 1ns / 1ps
package sdf_pkg;

  localparam int NUM_BUCKETS_DEF = 32;
  localparam int WAYS_DEF        = 4;
  localparam int VALUE_W         = 32;

  // Request state as it travels down the way cells.
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               first;   // clear the set before lookup
    logic               found;   // matched in an earlier way
    logic               placed;  // recorded in an earlier way
  } sdf_item_t;

endpackage

>>> hdl/sdf_bucket.sv
// Bucket index front end: value modulo bucket count, one register stage.
`timescale 1ns / 1ps
module sdf_bucket #(
  parameter int NUM_BUCKETS = sdf_pkg::NUM_BUCKETS_DEF,
  parameter int BW          = 5
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            in_vld,
  input  logic [sdf_pkg::VALUE_W-1:0]     in_value,
  input  logic                            in_first,
  output logic                            out_vld,
  output sdf_pkg::sdf_item_t              out_item,
  output logic [BW-1:0]                   out_bucket
);
  import sdf_pkg::*;

  localparam bit IS_POW2 = (NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0;

  logic               vld_r;
  logic [VALUE_W-1:0] value_r;
  logic               first_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      value_r <= in_value;
      first_r <= in_first;
    end
  end

  generate
    if (NUM_BUCKETS == 1) begin : g_one
      assign out_bucket = '0;
    end else if (IS_POW2) begin : g_pow2
      assign out_bucket = value_r[BW-1:0];
    end else begin : g_recip
      // Quotient estimate by reciprocal is exact or one low, so the
      // remainder stays below twice the bucket count.
      localparam logic [VALUE_W-1:0] RECIP = VALUE_W'((64'd1 << 32) / NUM_BUCKETS);
      localparam logic [BW:0]        NB_LO = (BW + 1)'(NUM_BUCKETS);

      logic [2*VALUE_W-1:0] prod;
      logic [VALUE_W-1:0]   q_r;
      logic [BW:0]          qn_lo;
      logic [BW:0]          rem;

      assign prod = {{VALUE_W{1'b0}}, in_value} * {{VALUE_W{1'b0}}, RECIP};

      always_ff @(posedge clk) begin
        if (en) begin
          q_r <= prod[2*VALUE_W-1:VALUE_W];
        end
      end

      assign qn_lo      = q_r[BW:0] * NB_LO;
      assign rem        = value_r[BW:0] - qn_lo;
      assign out_bucket = (rem >= NB_LO) ? BW'(rem - NB_LO) : BW'(rem);
    end
  endgenerate

  assign out_vld         = vld_r;
  assign out_item.value  = value_r;
  assign out_item.first  = first_r;
  assign out_item.found  = 1'b0;
  assign out_item.placed = 1'b0;

endmodule

>>> hdl/sdf_cell.sv
// One way of the seen set: value store, valid bits, compare and record.
`timescale 1ns / 1ps
module sdf_cell #(
  parameter int NUM_BUCKETS = sdf_pkg::NUM_BUCKETS_DEF,
  parameter int BW          = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  sdf_pkg::sdf_item_t in_item,
  input  logic [BW-1:0]      in_bucket,
  output logic               out_vld,
  output sdf_pkg::sdf_item_t out_item,
  output logic [BW-1:0]      out_bucket
);
  import sdf_pkg::*;

  logic [VALUE_W-1:0]     mem [NUM_BUCKETS];
  logic [NUM_BUCKETS-1:0] valid_r;
  logic [NUM_BUCKETS-1:0] valid_nxt;
  logic                   vld_r;
  sdf_item_t              item_r;
  logic [BW-1:0]          bucket_r;
  logic [VALUE_W-1:0]     rd_r;
  logic                   valid_eff;
  logic                   hit;
  logic                   place;
  logic                   wr;

  // A first-flagged request sees this way empty; the clear moves down the
  // chain with it, so requests ahead have already used the old contents.
  assign valid_eff = valid_r[bucket_r] && !item_r.first;
  assign hit       = valid_eff && (rd_r == item_r.value);
  assign place     = vld_r && !item_r.found && !item_r.placed && !valid_eff;
  assign wr        = en && place;

  always_comb begin
    valid_nxt = valid_r;
    if (en && vld_r) begin
      if (item_r.first) begin
        valid_nxt = '0;
      end
      if (place) begin
        valid_nxt[bucket_r] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      vld_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (en) begin
        vld_r <= in_vld;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r   <= in_item;
      bucket_r <= in_bucket;
    end
  end

  // Store write and registered read; forward a write to the same bucket.
  always_ff @(posedge clk) begin
    if (wr) begin
      mem[bucket_r] <= item_r.value;
    end
    if (en) begin
      if (wr && (bucket_r == in_bucket)) begin
        rd_r <= item_r.value;
      end else begin
        rd_r <= mem[in_bucket];
      end
    end
  end

  assign out_vld         = vld_r;
  assign out_bucket      = bucket_r;
  assign out_item.value  = item_r.value;
  assign out_item.first  = item_r.first;
  assign out_item.found  = item_r.found | hit;
  assign out_item.placed = item_r.placed | place;

endmodule

>>> hdl/stream_duplicate_filter.sv
// Stream duplicate filter: marks the first occurrence of each value in a list.
//
// Input channel in_*: one request per value; in_tdata carries the value and
// in_tuser[0] the first flag, which empties the seen set before the lookup.
// Output channel out_*: one result per request, in order; out_tdata echoes
// the value, out_tuser[0] is keep (first occurrence) and out_tuser[1] is
// overflow (bucket already held WAYS values, so the value passes as new and
// is not recorded).
// The seen set is NUM_BUCKETS buckets of WAYS values. A bucket stage forms
// the index, then a chain of WAYS cells, one per way, each holding that way
// of every bucket, compares and records as the request passes through.
// A request passes the bucket, cell and output registers. One request is taken
// each cycle the output does not stall: a cell does one read, compare and write.
// Reset empties the set and the pipeline. While a result waits in the output
// register with out_tready low, the whole chain holds and in_tready drops
// until that result is taken.
`timescale 1ns / 1ps
module stream_duplicate_filter #(
  parameter int NUM_BUCKETS = sdf_pkg::NUM_BUCKETS_DEF,
  parameter int WAYS        = sdf_pkg::WAYS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [sdf_pkg::VALUE_W-1:0] in_tdata,   // [31:0] value
  input  logic [0:0]                  in_tuser,   // [0] first
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [sdf_pkg::VALUE_W-1:0] out_tdata,  // [31:0] value_out
  output logic [1:0]                  out_tuser   // [0] keep, [1] overflow
);
  import sdf_pkg::*;

  localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;

  logic            en;
  logic            chain_vld    [WAYS+1];
  sdf_item_t       chain_item   [WAYS+1];
  logic [BW-1:0]   chain_bucket [WAYS+1];

  logic               out_vld_r;
  logic [VALUE_W-1:0] out_value_r;
  logic               out_keep_r;
  logic               out_over_r;

  // Advance everything whenever the output register is free or being taken.
  assign en        = !out_vld_r || out_tready;
  assign in_tready = en;

  sdf_bucket #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .BW          (BW)
  ) u_bucket (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_vld     (in_tvalid),
    .in_value   (in_tdata),
    .in_first   (in_tuser[0]),
    .out_vld    (chain_vld[0]),
    .out_item   (chain_item[0]),
    .out_bucket (chain_bucket[0])
  );

  generate
    for (genvar w = 0; w < WAYS; w++) begin : g_way
      sdf_cell #(
        .NUM_BUCKETS (NUM_BUCKETS),
        .BW          (BW)
      ) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_vld     (chain_vld[w]),
        .in_item    (chain_item[w]),
        .in_bucket  (chain_bucket[w]),
        .out_vld    (chain_vld[w+1]),
        .out_item   (chain_item[w+1]),
        .out_bucket (chain_bucket[w+1])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= chain_vld[WAYS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_value_r <= chain_item[WAYS].value;
      out_keep_r  <= !chain_item[WAYS].found;
      out_over_r  <= !chain_item[WAYS].found && !chain_item[WAYS].placed;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = {out_over_r, out_keep_r};

  // Bucket index of the last cell is not needed past the chain.
  logic unused_bucket;
  assign unused_bucket = ^chain_bucket[WAYS] ^ chain_item[WAYS].first;

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the stream duplicate filter, with a seen-set scoreboard.
`timescale 1ns / 1ps
module tb_top;
  import sdf_pkg::*;

  localparam int LATENCY    = WAYS_DEF + 2;
  localparam int IDLE_PCT   = 27;
  localparam int ITEM_COUNT = 450;
  localparam int STALL_MAX  = 2000;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               keep;
    logic               overflow;
  } dedup_verdict_t;

  // Tracks the seen set per list and the verdicts still owed by the block.
  class dedup_scoreboard;
    logic [VALUE_W-1:0] seen_tbl [NUM_BUCKETS_DEF][WAYS_DEF];
    int unsigned        fill_cnt [NUM_BUCKETS_DEF];
    dedup_verdict_t     verdict_q [$];
    int                 errors;

    function void note_request(logic [VALUE_W-1:0] value, logic first);
      int unsigned    bkt;
      logic           hit;
      dedup_verdict_t v;
      bkt = value % NUM_BUCKETS_DEF;
      hit = 1'b0;
      if (first) begin
        foreach (fill_cnt[i]) fill_cnt[i] = 0;
      end
      for (int w = 0; w < fill_cnt[bkt]; w++) begin
        if (seen_tbl[bkt][w] == value) hit = 1'b1;
      end
      v.value    = value;
      v.keep     = !hit;
      v.overflow = 1'b0;
      if (!hit) begin
        if (fill_cnt[bkt] < WAYS_DEF) begin
          seen_tbl[bkt][fill_cnt[bkt]] = value;
          fill_cnt[bkt]++;
        end else begin
          v.overflow = 1'b1;
        end
      end
      verdict_q.push_back(v);
    endfunction

    function void check_result(logic [VALUE_W-1:0] value, logic [1:0] flags);
      dedup_verdict_t exp_v;
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected result value %h flags %b", $time, value, flags);
        errors++;
        return;
      end
      exp_v = verdict_q.pop_front();
      if (value !== exp_v.value) begin
        $display("%0t: value mismatch expected %h actual %h", $time, exp_v.value, value);
        errors++;
      end
      if (flags[0] !== exp_v.keep) begin
        $display("%0t: keep mismatch for %h expected %b actual %b",
                 $time, exp_v.value, exp_v.keep, flags[0]);
        errors++;
      end
      if (flags[1] !== exp_v.overflow) begin
        $display("%0t: overflow mismatch for %h expected %b actual %b",
                 $time, exp_v.value, exp_v.overflow, flags[1]);
        errors++;
      end
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction
  endclass

  logic               clk;
  logic               rst_n      = 1'b0;
  logic               in_tvalid  = 1'b0;
  logic               in_tready;
  logic [VALUE_W-1:0] in_tdata   = '0;   // [31:0] value
  logic [0:0]         in_tuser   = '0;   // [0] first
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [VALUE_W-1:0] out_tdata;         // [31:0] value_out
  logic [1:0]         out_tuser;         // [0] keep, [1] overflow

  logic            steady = 1'b0;
  int              stall_cnt = 0;
  dedup_scoreboard sb;

  stream_duplicate_filter uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Note requests before results; latency keeps them apart anyway.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_request(in_tdata, in_tuser[0]);
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_MAX) begin
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  task automatic send_request(input logic [VALUE_W-1:0] value, input logic first);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid   <= 1'b1;
    in_tdata    <= value;
    in_tuser[0] <= first;
    do @(posedge clk); while (!in_tready);
  endtask

  // Mostly values from a few crowded buckets so that buckets fill and overflow.
  function automatic logic [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] v;
    if ($urandom_range(0, 99) < 15) return $urandom;
    v = ($urandom_range(0, 11) << 5) | $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) v = ~v;
    return v;
  endfunction

  initial begin
    logic [VALUE_W-1:0] list_vals [$];
    logic [VALUE_W-1:0] v;
    int                 sent;
    int                 list_len;
    logic               first;

    sb = new;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: duplicates, a full bucket, extremes and list restarts.
    send_request(32'h0000_0000, 1'b0);
    send_request(32'h0000_0000, 1'b0);
    send_request(32'h0000_0020, 1'b0);
    send_request(32'h0000_0040, 1'b0);
    send_request(32'h0000_0060, 1'b0);
    send_request(32'h0000_0080, 1'b0);  // bucket full: pass with overflow
    send_request(32'h0000_0080, 1'b0);  // still not recorded
    send_request(32'h0000_0060, 1'b0);  // known value in a full bucket
    send_request(32'h8000_0000, 1'b0);
    send_request(32'h7fff_ffff, 1'b0);
    send_request(32'hffff_ffff, 1'b0);
    send_request(32'hffff_ffff, 1'b0);
    send_request(32'h7fff_ffff, 1'b1);  // clear before lookup
    send_request(32'h0000_0000, 1'b0);
    send_request(32'h5555_5555, 1'b0);
    send_request(32'haaaa_aaaa, 1'b0);
    send_request(32'h0000_0080, 1'b0);
    send_request(32'h0000_0080, 1'b1);

    sent = 0;
    while (sent < ITEM_COUNT) begin
      list_len = $urandom_range(1, 40);
      list_vals.delete();
      for (int i = 0; i < list_len && sent < ITEM_COUNT; i++) begin
        steady = (sent >= 200 && sent < 280);
        if (i == 0) first = ($urandom_range(0, 9) != 0);
        else        first = ($urandom_range(0, 99) < 3);
        if (list_vals.size() > 0 && $urandom_range(0, 99) < 20)
          v = list_vals[$urandom_range(0, list_vals.size() - 1)];
        else
          v = pick_value();
        list_vals.push_back(v);
        send_request(v, first);
        sent++;
      end
    end
    steady = 1'b0;
    in_tvalid <= 1'b0;

    while (sb.pending() > 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
